[rtl/core/brs_pkg.sv]
`default_nettype none
package brs_pkg;

  localparam int MaxDims  = 3;
  localparam int FracBits = 16;
  localparam int NoiseFrac = 12;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  typedef enum logic [CfgIdxW-1:0] {
    RegDims  = 3'd0,
    RegDt    = 3'd1,
    RegMpar  = 3'd2,
    RegMperp = 3'd3,
    RegMrot  = 3'd4,
    RegSpar  = 3'd5,
    RegSperp = 3'd6,
    RegSrot  = 3'd7
  } cfg_reg_e;

  // saturate a 66 bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    begin
      hi = 66'sd2147483647;
      lo = -66'sd2147483648;
      if (v > hi) sat32 = 32'sh7fffffff;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/brs_isqrt.sv]
`default_nettype none
// bit-serial integer square root of a 64 bit value, one result bit a cycle
module brs_isqrt
  import brs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] x_i,
  output logic             done_o,
  output logic [31:0]      root_o
);
  logic [63:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [63:0] src_q, src_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [65:0] trial;
  logic [65:0] remsh;

  always_comb begin
    remsh  = {rem_q, src_q[63:62]};
    trial  = {32'd0, root_q, 2'b01};
    rem_d  = rem_q;
    root_d = root_q;
    src_d  = src_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      root_d = '0;
      src_d  = x_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      src_d = {src_q[61:0], 2'b00};
      if (remsh >= trial) begin
        rem_d  = 64'(remsh - trial);
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = remsh[63:0];
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
      end
    end
    if (!busy_q && cnt_q == 6'd32) done_o = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= (done_o && !start_i) ? 6'd0 : cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    src_q  <= src_d;
  end

  assign root_o = root_q;
endmodule
`default_nettype wire

[rtl/core/brs_divider.sv]
`default_nettype none
// restoring divider: (num << FRAC) / den, truncated toward zero, saturated
module brs_divider
  import brs_pkg::*;
#(
  parameter int FRAC = FracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic [31:0]        den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);
  localparam int NW = 32 + FRAC;
  logic [NW-1:0] dvd_q, dvd_d;
  logic [32:0]   rem_q, rem_d;
  logic [31:0]   den_q, den_d;
  logic          neg_q, neg_d;
  logic [6:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          fin_q, fin_d;
  logic [33:0]   sh;
  logic [NW-1:0] mag;
  logic [32:0]   absn;
  logic signed [65:0] sq;

  always_comb begin
    absn   = num_i[31] ? 33'(-$signed({num_i[31], num_i})) : {1'b0, num_i};
    mag    = NW'(absn) << FRAC;
    sh     = {rem_q, dvd_q[NW-1]};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    fin_d  = 1'b0;
    if (start_i) begin
      dvd_d  = mag;
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[31];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {2'b00, den_q}) begin
        rem_d = 33'(sh - {2'b00, den_q});
        dvd_d = {dvd_q[NW-2:0], 1'b1};
      end else begin
        rem_d = sh[32:0];
        dvd_d = {dvd_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(NW - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
    sq = neg_q ? -$signed({2'b00, 64'(dvd_q)}) : $signed({2'b00, 64'(dvd_q)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = fin_q;
  assign quo_o  = sat32(sq);
endmodule
`default_nettype wire

[rtl/core/brs_mul.sv]
`default_nettype none
// shared multiplier: exact signed product, floor shift, saturate; registered
module brs_mul
  import brs_pkg::*;
#(
  parameter int FRAC = FracBits
) (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  input  wire logic               noise_i,
  output logic signed [31:0]      p_o
);
  logic signed [63:0] prod;
  logic signed [65:0] shf;
  always_comb begin
    prod = a_i * b_i;
    if (noise_i) shf = 66'(prod >>> NoiseFrac);
    else shf = 66'(prod >>> FRAC);
  end
  always_ff @(posedge clk_i) begin
    p_o <= sat32(shf);
  end
endmodule
`default_nettype wire

[rtl/core/brownian_rod_step_unit.sv]
`default_nettype none
// Brownian rod Euler step.
// Input channel: in_valid_i / in_stall_o with force, torque and five noise
// samples as separate ports. A word is taken when valid is high and stall low.
// Output channel: out_valid_o / out_stall_i carrying position, orientation
// and accumulated travel after the step. One result per input word.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i, to be written while idle;
// the block itself does not enforce this. The run time of a word is set by
// the single shared multiplier, used in turn for every product but the
// sums of squares, and by the bit-serial square root and the restoring
// divider run for each normalized vector: the body frame in 3D and the new
// orientation in both modes. Items are processed one at a time; stall stays
// high while an item is in work or a result waits, so no new word is taken
// until the result has left.
// Reset: position and travel clear, orientation becomes (1.0, 0, 0),
// registers take their reset values. When the receiver stalls, the result
// holds and no new word is taken until it is delivered.
module brownian_rod_step_unit
  import brs_pkg::*;
#(
  parameter int FRAC = FracBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic signed [31:0]  force_x_i,
  input  wire logic signed [31:0]  force_y_i,
  input  wire logic signed [31:0]  force_z_i,
  input  wire logic signed [31:0]  torque_x_i,
  input  wire logic signed [31:0]  torque_y_i,
  input  wire logic signed [31:0]  torque_z_i,
  input  wire logic signed [15:0]  noise_parallel_i,
  input  wire logic signed [15:0]  noise_perp_first_i,
  input  wire logic signed [15:0]  noise_perp_second_i,
  input  wire logic signed [15:0]  noise_rot_first_i,
  input  wire logic signed [15:0]  noise_rot_second_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [31:0]       pos_x_o,
  output logic signed [31:0]       pos_y_o,
  output logic signed [31:0]       pos_z_o,
  output logic signed [31:0]       dir_x_o,
  output logic signed [31:0]       dir_y_o,
  output logic signed [31:0]       dir_z_o,
  output logic signed [31:0]       travel_x_o,
  output logic signed [31:0]       travel_y_o,
  output logic signed [31:0]       travel_z_o
);
  localparam logic signed [31:0] One = 32'sd1 <<< FRAC;
  localparam logic signed [31:0] NearTol = 32'(((64'sd1 << FRAC) + 50) / 100);

  // microcode slots
  typedef enum logic [4:0] {
    SIdle, SFrame, SNrm1, SNrm2, SNrm3, SNrm4, SCross1, SKs, SProj,
    SDrift1, SDrift2, SKick, STcross, SRot, SNrm5, SFin, SOut
  } state_e;

  state_e state_q;
  logic [1:0] dims_q;
  logic [30:0] dt_q, mpar_q, mperp_q, mrot_q, spar_q, sperp_q, srot_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] dir_q [3];
  logic signed [31:0] trv_q [3];
  logic signed [31:0] old_q [3];
  logic signed [31:0] f_q [3];
  logic signed [31:0] t_q [3];
  logic signed [15:0] nz_q [5];
  logic signed [31:0] b0_q [3];
  logic signed [31:0] b1_q [3];
  logic signed [31:0] nu_q [3];
  logic signed [31:0] du_q [3];
  logic signed [31:0] tmp_q [3];
  logic signed [31:0] k_q [8];
  logic signed [31:0] proj_q, para_q, acc_q;
  logic [5:0] step_q;
  logic [1:0] idx_q;
  logic d3_q;
  logic rotv_q;
  logic [63:0] ssum_q;
  logic [31:0] nrm_q;
  logic out_valid_q;

  logic signed [31:0] ma, mb, mp;
  logic mnoise;
  logic sq_start, sq_done;
  logic [31:0] sq_root;
  logic dv_start, dv_done;
  logic signed [31:0] dv_num, dv_quo;

  brs_mul #(.FRAC(FRAC)) u_mul (
    .clk_i, .a_i(ma), .b_i(mb), .noise_i(mnoise), .p_o(mp)
  );
  brs_isqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .x_i(ssum_q), .done_o(sq_done), .root_o(sq_root)
  );
  brs_divider #(.FRAC(FRAC)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(nrm_q),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    sadd = sat32(66'(a) + 66'(b));
  endfunction
  function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    ssub = sat32(66'(a) - 66'(b));
  endfunction

  // multiplier operand selection by state, step and component
  always_comb begin
    ma = '0;
    mb = '0;
    mnoise = 1'b0;
    unique case (state_q)
      SCross1, STcross: begin
        // step 0..5 : six products of the cross product
        logic signed [31:0] xa [3];
        logic signed [31:0] xb [3];
        for (int i = 0; i < 3; i++) begin
          xa[i] = (state_q == SCross1) ? dir_q[i] : t_q[i];
          xb[i] = (state_q == SCross1) ? b0_q[i] : dir_q[i];
        end
        case (step_q[2:0])
          3'd0: begin ma = xa[1]; mb = xb[2]; end
          3'd1: begin ma = xa[2]; mb = xb[1]; end
          3'd2: begin ma = xa[2]; mb = xb[0]; end
          3'd3: begin ma = xa[0]; mb = xb[2]; end
          3'd4: begin ma = xa[0]; mb = xb[1]; end
          default: begin ma = xa[1]; mb = xb[0]; end
        endcase
      end
      SKs: begin
        case (step_q[2:0])
          3'd0: begin ma = {1'b0, mpar_q}; mb = {1'b0, dt_q}; end
          3'd1: begin ma = {1'b0, mperp_q}; mb = {1'b0, dt_q}; end
          3'd2: begin ma = {1'b0, mrot_q}; mb = {1'b0, dt_q}; end
          3'd3: begin ma = {1'b0, spar_q}; mb = 32'(nz_q[0]); mnoise = 1'b1; end
          3'd4: begin ma = {1'b0, sperp_q}; mb = 32'(nz_q[1]); mnoise = 1'b1; end
          3'd5: begin ma = {1'b0, sperp_q}; mb = 32'(nz_q[2]); mnoise = 1'b1; end
          3'd6: begin ma = {1'b0, srot_q}; mb = 32'(nz_q[3]); mnoise = 1'b1; end
          default: begin ma = {1'b0, srot_q}; mb = 32'(nz_q[4]); mnoise = 1'b1; end
        endcase
      end
      SProj: begin ma = dir_q[idx_q]; mb = f_q[idx_q]; end
      SDrift1: begin ma = dir_q[idx_q]; mb = proj_q; end
      SDrift2: begin
        if (step_q[0] == 1'b0) begin ma = k_q[0]; mb = para_q; end
        else begin ma = k_q[1]; mb = ssub(f_q[idx_q], para_q); end
      end
      SKick: begin
        case (step_q[1:0])
          2'd0: begin ma = k_q[3]; mb = dir_q[idx_q]; end
          2'd1: begin ma = k_q[4]; mb = b0_q[idx_q]; end
          default: begin ma = k_q[5]; mb = b1_q[idx_q]; end
        endcase
      end
      SRot: begin
        case (step_q[1:0])
          2'd0: begin ma = du_q[idx_q]; mb = k_q[2]; end
          2'd1: begin ma = k_q[6]; mb = b0_q[idx_q]; end
          default: begin ma = k_q[7]; mb = b1_q[idx_q]; end
        endcase
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign in_stall_o  = (state_q != SIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign dv_num = rotv_q ? nu_q[idx_q] : b0_q[idx_q];

  always_comb begin
    sq_start = (state_q == SNrm1);
    dv_start = (state_q == SNrm3);
  end

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      out_valid_q <= 1'b0;
      dims_q <= 2'd3;
      dt_q <= 31'd1 << FRAC;
      mpar_q <= 31'd1 << FRAC;
      mperp_q <= 31'd1 << (FRAC - 1);
      mrot_q <= 31'd1 << FRAC;
      spar_q <= '0;
      sperp_q <= '0;
      srot_q <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        trv_q[i] <= '0;
        dir_q[i] <= (i == 0) ? One : 32'sd0;
      end
      step_q <= '0;
      idx_q <= '0;
      d3_q <= 1'b1;
      rotv_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          RegDims:  dims_q  <= cfg_data_i[1:0];
          RegDt:    dt_q    <= cfg_data_i;
          RegMpar:  mpar_q  <= cfg_data_i;
          RegMperp: mperp_q <= cfg_data_i;
          RegMrot:  mrot_q  <= cfg_data_i;
          RegSpar:  spar_q  <= cfg_data_i;
          RegSperp: sperp_q <= cfg_data_i;
          RegSrot:  srot_q  <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        SIdle: begin
          if (in_acc) begin
            logic d3;
            d3 = (dims_q == 2'd3) && (MaxDims == 3);
            d3_q <= d3;
            f_q[0] <= force_x_i;
            f_q[1] <= force_y_i;
            f_q[2] <= d3 ? force_z_i : 32'sd0;
            t_q[0] <= torque_x_i;
            t_q[1] <= torque_y_i;
            t_q[2] <= torque_z_i;
            nz_q[0] <= noise_parallel_i;
            nz_q[1] <= noise_perp_first_i;
            nz_q[2] <= noise_perp_second_i;
            nz_q[3] <= noise_rot_first_i;
            nz_q[4] <= noise_rot_second_i;
            if (!d3) begin
              dir_q[2] <= '0;
              pos_q[2] <= '0;
            end
            for (int i = 0; i < 2; i++) old_q[i] <= pos_q[i];
            old_q[2] <= d3 ? pos_q[2] : 32'sd0;
            state_q <= SFrame;
          end
        end
        SFrame: begin
          // body frame from the starting orientation
          logic signed [31:0] ax;
          ax = dir_q[0][31] ? ssub(32'sd0, dir_q[0]) : dir_q[0];
          for (int i = 0; i < 3; i++) b1_q[i] <= '0;
          if (!d3_q) begin
            b0_q[0] <= dir_q[1];
            b0_q[1] <= ssub(32'sd0, dir_q[0]);
            b0_q[2] <= '0;
            state_q <= SKs;
          end else begin
            if (ssub(One, ax) > NearTol) begin
              b0_q[0] <= '0;
              b0_q[1] <= dir_q[2];
              b0_q[2] <= ssub(32'sd0, dir_q[1]);
            end else begin
              b0_q[0] <= ssub(32'sd0, dir_q[2]);
              b0_q[1] <= '0;
              b0_q[2] <= dir_q[0];
            end
            rotv_q <= 1'b0;
            idx_q <= '0;
            ssum_q <= '0;
            state_q <= SNrm2;
          end
          step_q <= '0;
        end
        SNrm2: begin
          // sum of squares, exact 64 bit, one component a cycle
          logic signed [31:0] v;
          v = rotv_q ? nu_q[idx_q] : b0_q[idx_q];
          ssum_q <= ssum_q + 64'(v * v);
          if (idx_q == (d3_q ? 2'd2 : 2'd1)) begin
            idx_q <= '0;
            state_q <= SNrm1;
          end else idx_q <= idx_q + 2'd1;
        end
        SNrm1: state_q <= SNrm4;
        SNrm4: begin
          if (sq_done) begin
            nrm_q <= sq_root;
            if (sq_root == '0) begin
              if (rotv_q) begin
                nu_q[0] <= One; nu_q[1] <= '0; nu_q[2] <= '0;
                state_q <= SFin;
              end else begin
                b0_q[0] <= One; b0_q[1] <= '0; b0_q[2] <= '0;
                state_q <= SCross1;
              end
            end else state_q <= SNrm3;
          end
        end
        SNrm3: state_q <= SNrm5;
        SNrm5: begin
          if (dv_done) begin
            if (rotv_q) tmp_q[idx_q] <= dv_quo;
            else tmp_q[idx_q] <= dv_quo;
            if (idx_q == (d3_q ? 2'd2 : 2'd1)) begin
              idx_q <= '0;
              state_q <= rotv_q ? SFin : SCross1;
              if (rotv_q) begin
                for (int i = 0; i < 2; i++) nu_q[i] <= (i == idx_q) ? dv_quo : tmp_q[i];
                nu_q[2] <= (idx_q == 2'd2) ? dv_quo : (d3_q ? tmp_q[2] : 32'sd0);
              end else begin
                b0_q[0] <= tmp_q[0];
                b0_q[1] <= tmp_q[1];
                b0_q[2] <= dv_quo;
              end
            end else begin
              idx_q <= idx_q + 2'd1;
              state_q <= SNrm3;
            end
          end
        end
        SCross1, STcross: begin
          // the registered product arrives in the cycle after its operands
          if (step_q != 6'd0) begin
            logic [2:0] k;
            k = 3'(step_q - 6'd1);
            if (k[0] == 1'b0) acc_q <= mp;
            else begin
              if (state_q == SCross1) b1_q[k[2:1]] <= ssub(acc_q, mp);
              else du_q[k[2:1]] <= ssub(acc_q, mp);
            end
          end
          if (step_q == 6'd6) begin
            step_q <= '0;
            if (state_q == SCross1) state_q <= SKs;
            else begin
              idx_q <= '0;
              for (int i = 0; i < 3; i++) nu_q[i] <= dir_q[i];
              state_q <= SRot;
            end
          end else step_q <= step_q + 6'd1;
        end
        SKs: begin
          if (step_q != 6'd0) k_q[3'(step_q - 6'd1)] <= mp;
          if (step_q == 6'd8) begin
            step_q <= '0;
            idx_q <= '0;
            proj_q <= '0;
            state_q <= SProj;
          end else step_q <= step_q + 6'd1;
        end
        SProj: begin
          if (step_q == 6'd0) step_q <= 6'd1;
          else begin
            proj_q <= sadd(proj_q, mp);
            step_q <= '0;
            if (idx_q == (d3_q ? 2'd2 : 2'd1)) begin
              idx_q <= '0;
              state_q <= SDrift1;
            end else idx_q <= idx_q + 2'd1;
          end
        end
        SDrift1: begin
          if (step_q == 6'd0) step_q <= 6'd1;
          else begin
            para_q <= mp;
            step_q <= '0;
            state_q <= SDrift2;
          end
        end
        SDrift2: begin
          if (step_q == 6'd1) acc_q <= mp;
          if (step_q == 6'd2) begin
            pos_q[idx_q] <= sadd(pos_q[idx_q], sadd(acc_q, mp));
            step_q <= '0;
            if (idx_q == (d3_q ? 2'd2 : 2'd1)) begin
              idx_q <= '0;
              state_q <= SKick;
            end else begin
              idx_q <= idx_q + 2'd1;
              state_q <= SDrift1;
            end
          end else step_q <= step_q + 6'd1;
        end
        SKick: begin
          if (step_q != 6'd0) pos_q[idx_q] <= sadd(pos_q[idx_q], mp);
          if (step_q == (d3_q ? 6'd3 : 6'd2)) begin
            step_q <= '0;
            if (idx_q == (d3_q ? 2'd2 : 2'd1)) begin
              idx_q <= '0;
              state_q <= STcross;
            end else idx_q <= idx_q + 2'd1;
          end else step_q <= step_q + 6'd1;
        end
        SRot: begin
          if (step_q != 6'd0) nu_q[idx_q] <= sadd(nu_q[idx_q], mp);
          if (step_q == (d3_q ? 6'd3 : 6'd2)) begin
            step_q <= '0;
            if (idx_q == (d3_q ? 2'd2 : 2'd1)) begin
              idx_q <= '0;
              if (!d3_q) nu_q[2] <= '0;
              rotv_q <= 1'b1;
              ssum_q <= '0;
              state_q <= SNrm2;
            end else idx_q <= idx_q + 2'd1;
          end else step_q <= step_q + 6'd1;
        end
        SFin: begin
          for (int i = 0; i < 3; i++) dir_q[i] <= nu_q[i];
          for (int i = 0; i < 2; i++) trv_q[i] <= sadd(trv_q[i], ssub(pos_q[i], old_q[i]));
          if (d3_q) trv_q[2] <= sadd(trv_q[2], ssub(pos_q[2], old_q[2]));
          rotv_q <= 1'b0;
          state_q <= SOut;
        end
        SOut: begin
          out_valid_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign pos_x_o = pos_q[0];
  assign pos_y_o = pos_q[1];
  assign pos_z_o = pos_q[2];
  assign dir_x_o = dir_q[0];
  assign dir_y_o = dir_q[1];
  assign dir_z_o = dir_q[2];
  assign travel_x_o = trv_q[0];
  assign travel_y_o = trv_q[1];
  assign travel_z_o = trv_q[2];
endmodule
`default_nettype wire
